// ===== rtl/core/rat_pkg.sv =====
package rat_pkg;

  localparam int REGION_SLOTS = 16;
  localparam int SLOT_W       = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int ADDR_W       = 64;
  localparam int LEN_W        = 32;
  localparam int ENTRY_SLOT_W = 4;
  localparam int ACTION_W     = 2;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_V2P   = 2'd1,
    ACT_P2V   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] virt_base;
    logic [ADDR_W-1:0] phys_base;
    logic [LEN_W-1:0]  length;
  } region_t;

  typedef struct packed {
    logic      en;
    slot_idx_t slot;
    region_t   region;
  } table_wr_t;

endpackage

// ===== rtl/core/rat_table.sv =====
module rat_table (
  input  logic               clk,
  input  logic               rst_n,
  input  rat_pkg::table_wr_t wr,
  input  rat_pkg::slot_idx_t rd_addr,
  output rat_pkg::region_t   rd_region
);
  import rat_pkg::*;

  region_t                 mem [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] valid_r;
  region_t                 rd_data_r;
  logic                    rd_valid_r;

  // Slots never written since reset read back with zero length, so they never match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= wr.region;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r  <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  always_comb begin
    rd_region = rd_data_r;
    if (!rd_valid_r) begin
      rd_region = '0;
    end
  end

endmodule

// ===== rtl/core/region_address_translator.sv =====
// Region address translator.
// Input channel (in_valid/in_ready): one beat is either a table write
// (in_action write) or a lookup (virtual to physical, or physical to virtual).
// A write gives no result; the unused action code is
// taken and dropped. A lookup reads the region table one slot per cycle from
// the single read port of the table memory, lowest slot first, and stops at
// the first slot whose range holds the address.
// Result channel (out_valid/out_ready): one beat per lookup, held in an output
// register. The lookup scans, then enters an emit state, and its result is
// loaded as it leaves that state; a miss has out_not_found set and a
// zero address and slot. in_ready is high only between lookups, so a lookup
// keeps the input side closed until its result is loaded, and a write does not.
// A waiting result does not hold off the next input beat; the next lookup
// scans and then waits in the emit state until the output register is free.
// Reset marks every table slot empty (zero length) and drops any pending
// result.
module region_address_translator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_entry_slot,
  input  logic [63:0] in_region_virtual_base,
  input  logic [63:0] in_region_physical_base,
  input  logic [31:0] in_region_length,
  input  logic [63:0] in_lookup_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_translated_address,
  output logic        out_not_found,
  output logic [3:0]  out_matched_slot
);
  import rat_pkg::*;

  state_t            state_r, state_nxt;
  slot_idx_t         idx_r;
  logic              dir_v2p_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] offset_r;
  logic [ADDR_W-1:0] other_r;
  logic              miss_r;
  logic [3:0]        hit_slot_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_miss_r;
  logic [3:0]        out_slot_r;

  action_t           action;
  logic              in_fire;
  logic              is_lookup;
  table_wr_t         tbl_wr;
  slot_idx_t         rd_addr;
  region_t           rd_region;

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] other;
  logic [ADDR_W-1:0] diff;
  logic              hit;
  logic              last;
  logic              out_free;
  logic [31:0]       idx_wide;

  rat_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (tbl_wr),
    .rd_addr   (rd_addr),
    .rd_region (rd_region)
  );

  assign action   = action_t'(in_action);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last     = (idx_r == slot_idx_t'(REGION_SLOTS - 1));
  assign idx_wide = 32'(idx_r);

  always_comb begin
    unique case (action)
      ACT_V2P, ACT_P2V: is_lookup = 1'b1;
      ACT_WRITE, ACT_NONE: is_lookup = 1'b0;
      default: is_lookup = 1'b0;
    endcase
  end

  // Compare against the slot read in the previous cycle.
  always_comb begin
    base  = dir_v2p_r ? rd_region.virt_base : rd_region.phys_base;
    other = dir_v2p_r ? rd_region.phys_base : rd_region.virt_base;
    diff  = addr_r - base;
    hit   = (addr_r >= base) && (diff < {32'b0, rd_region.length});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_lookup) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    tbl_wr   = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready          = 1'b1;
        tbl_wr.en         = in_fire && (action == ACT_WRITE) &&
                            (32'(in_entry_slot) < REGION_SLOTS);
        tbl_wr.slot       = slot_idx_t'(in_entry_slot);
        tbl_wr.region     = '{virt_base: in_region_virtual_base,
                              phys_base: in_region_physical_base,
                              length:    in_region_length};
      end
      ST_SCAN: begin
        if (!last) begin
          rd_addr = idx_r + slot_idx_t'(1);
        end
      end
      ST_EMIT: begin
        rd_addr = '0;
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        idx_r <= '0;
      end else if (state_r == ST_SCAN && !hit && !last) begin
        idx_r <= idx_r + slot_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      addr_r    <= in_lookup_address;
      dir_v2p_r <= (action == ACT_V2P);
    end
    if (state_r == ST_SCAN) begin
      if (hit) begin
        offset_r   <= diff;
        other_r    <= other;
        miss_r     <= 1'b0;
        hit_slot_r <= idx_wide[3:0];
      end else if (last) begin
        offset_r   <= '0;
        other_r    <= '0;
        miss_r     <= 1'b1;
        hit_slot_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_addr_r <= other_r + offset_r;
      out_miss_r <= miss_r;
      out_slot_r <= hit_slot_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_translated_address = out_addr_r;
  assign out_not_found          = out_miss_r;
  assign out_matched_slot       = out_slot_r;

endmodule

// ===== rtl/core/rat_checker.sv =====
module rat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_translated_address,
  input logic        out_not_found,
  input logic [3:0]  out_matched_slot
);
  import rat_pkg::*;

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_translated_address) &&
      $stable(out_not_found) && $stable(out_matched_slot))
    else $error("stalled result beat changed");

  // A miss carries a zero address and slot.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_found |-> out_translated_address == '0 && out_matched_slot == '0)
    else $error("miss result carries nonzero fields");

  // A lookup keeps the input side closed while the table is scanned.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_V2P || in_action == ACT_P2V) |=> !in_ready)
    else $error("input taken during a scan");

  // A new result only comes out of a lookup that held the input side closed.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a lookup");

endmodule

bind region_address_translator rat_checker u_rat_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .in_action              (in_action),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_translated_address (out_translated_address),
  .out_not_found          (out_not_found),
  .out_matched_slot       (out_matched_slot)
);

// ===== test/region_address_translator_tb.sv =====
module region_address_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rat_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 2 * (REGION_SLOTS + 3);
  localparam int FIRST_RANDOM    = 150;
  localparam int STEADY_RANDOM   = 100;
  localparam int BACKLOG_RANDOM  = 30;
  localparam int LAST_RANDOM     = 150;

  typedef struct packed {
    action_t           action;
    logic [3:0]        slot;
    logic [ADDR_W-1:0] vbase;
    logic [ADDR_W-1:0] pbase;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic              known;
    logic [ADDR_W-1:0] exp_addr;
    logic              exp_miss;
    logic [3:0]        exp_slot;
  } region_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              miss;
    logic [3:0]        slot;
  } translation_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic [3:0]        in_entry_slot;
  logic [63:0]       in_region_virtual_base;
  logic [63:0]       in_region_physical_base;
  logic [31:0]       in_region_length;
  logic [63:0]       in_lookup_address;
  logic              out_valid;
  logic              out_ready;
  logic [63:0]       out_translated_address;
  logic              out_not_found;
  logic [3:0]        out_matched_slot;

  // Shadow of the region table, kept in step with accepted beats.
  logic [ADDR_W-1:0] virt_tab [REGION_SLOTS];
  logic [ADDR_W-1:0] phys_tab [REGION_SLOTS];
  logic [LEN_W-1:0]  len_tab  [REGION_SLOTS];

  translation_t      pending_translations[$];
  region_beat_t      cur_beat;

  int                mismatches;
  int                writes_seen;
  int                lookups_seen;
  int                ignored_seen;
  int                hits_seen;
  int                misses_seen;
  bit                no_idle;
  int                hold_requests;

  region_address_translator uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_action              (in_action),
    .in_entry_slot          (in_entry_slot),
    .in_region_virtual_base (in_region_virtual_base),
    .in_region_physical_base(in_region_physical_base),
    .in_region_length       (in_region_length),
    .in_lookup_address      (in_lookup_address),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_translated_address (out_translated_address),
    .out_not_found          (out_not_found),
    .out_matched_slot       (out_matched_slot)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Applies one beat to the shadow table; returns 1 when the beat yields a result.
  function automatic bit translate_beat(input region_beat_t b, output translation_t t);
    logic [ADDR_W-1:0] from_base;
    logic [ADDR_W-1:0] offset;
    t.addr = '0;
    t.miss = 1'b1;
    t.slot = '0;
    case (b.action)
      ACT_WRITE: begin
        if (int'(b.slot) < REGION_SLOTS) begin
          virt_tab[b.slot] = b.vbase;
          phys_tab[b.slot] = b.pbase;
          len_tab[b.slot]  = b.len;
        end
        return 1'b0;
      end
      ACT_V2P, ACT_P2V: begin
        for (int k = 0; k < REGION_SLOTS; k++) begin
          from_base = (b.action == ACT_V2P) ? virt_tab[k] : phys_tab[k];
          offset    = b.addr - from_base;
          // The end is compared as a distance, so a range never wraps past zero.
          if (b.addr >= from_base && offset < {{(ADDR_W-LEN_W){1'b0}}, len_tab[k]}) begin
            t.addr = ((b.action == ACT_V2P) ? phys_tab[k] : virt_tab[k]) + offset;
            t.miss = 1'b0;
            t.slot = 4'(k);
            return 1'b1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic region_beat_t write_row(input logic [3:0] slot,
                                             input logic [ADDR_W-1:0] vbase,
                                             input logic [ADDR_W-1:0] pbase,
                                             input logic [LEN_W-1:0] len);
    region_beat_t b;
    b = '0;
    b.action = ACT_WRITE;
    b.slot   = slot;
    b.vbase  = vbase;
    b.pbase  = pbase;
    b.len    = len;
    b.addr   = {$urandom, $urandom};
    return b;
  endfunction

  function automatic region_beat_t lookup_row(input action_t action,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic known,
                                              input logic [ADDR_W-1:0] exp_addr,
                                              input logic exp_miss,
                                              input logic [3:0] exp_slot);
    region_beat_t b;
    b.action   = action;
    b.slot     = 4'($urandom);
    b.vbase    = {$urandom, $urandom};
    b.pbase    = {$urandom, $urandom};
    b.len      = $urandom;
    b.addr     = addr;
    b.known    = known;
    b.exp_addr = exp_addr;
    b.exp_miss = exp_miss;
    b.exp_slot = exp_slot;
    return b;
  endfunction

  // Mostly lookups aimed at, or just outside, regions already in the table.
  function automatic region_beat_t random_region_beat();
    region_beat_t      b;
    int                pick;
    int                k;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    b        = lookup_row(ACT_V2P, {$urandom, $urandom}, 1'b0, '0, 1'b0, '0);
    pick     = $urandom_range(99);
    if (pick < 5) begin
      b.action = ACT_NONE;
    end else if (pick < 30) begin
      b.action = ACT_WRITE;
      if ($urandom_range(1) == 0) begin
        // Clustered bases make slots overlap, and high physical bases run past the top.
        b.vbase = 64'h4000 + 64'($urandom_range(16'hFFFF));
        b.pbase = 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(16'hFFFF));
      end
      pick = $urandom_range(99);
      if (pick < 60) b.len = $urandom_range(4096, 1);
      else if (pick < 75) b.len = '0;
      else if (pick < 90) b.len = $urandom;
      else b.len = '1;
    end else begin
      b.action = ($urandom_range(1) == 0) ? ACT_V2P : ACT_P2V;
      k    = $urandom_range(REGION_SLOTS - 1);
      base = (b.action == ACT_V2P) ? virt_tab[k] : phys_tab[k];
      len  = len_tab[k];
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (len != 0) b.addr = base + 64'($urandom_range(len - 1, 0));
      end else if (pick < 70) begin
        b.addr = base + {{(ADDR_W-LEN_W){1'b0}}, len};
      end else if (pick < 80) begin
        b.addr = base - 64'd1;
      end
    end
    return b;
  endfunction

  task automatic send_beat(input region_beat_t b);
    if (!no_idle) begin
      while ($urandom_range(99) < 38) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    cur_beat                = b;
    in_action               = b.action;
    in_entry_slot           = b.slot;
    in_region_virtual_base  = b.vbase;
    in_region_physical_base = b.pbase;
    in_region_length        = b.len;
    in_lookup_address       = b.addr;
    in_valid                = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    while (pending_translations.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    translation_t got;
    translation_t want;
    translation_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.addr = out_translated_address;
        got.miss = out_not_found;
        got.slot = out_matched_slot;
        if (pending_translations.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: addr %h miss %b slot %0d",
                                    got.addr, got.miss, got.slot));
        end else begin
          want = pending_translations.pop_front();
          if (got.addr !== want.addr)
            report_mismatch($sformatf("translated address %h, expected %h", got.addr, want.addr));
          if (got.miss !== want.miss)
            report_mismatch($sformatf("not_found %b, expected %b", got.miss, want.miss));
          if (got.slot !== want.slot)
            report_mismatch($sformatf("matched slot %0d, expected %0d", got.slot, want.slot));
          if (want.miss) misses_seen++;
          else hits_seen++;
        end
      end
      if (in_valid && in_ready) begin
        if (translate_beat(cur_beat, pred)) begin
          lookups_seen++;
          if (cur_beat.known) begin
            pred.addr = cur_beat.exp_addr;
            pred.miss = cur_beat.exp_miss;
            pred.slot = cur_beat.exp_slot;
          end
          pending_translations.push_back(pred);
        end else if (cur_beat.action == ACT_WRITE) begin
          writes_seen++;
        end else begin
          ignored_seen++;
        end
      end
    end
  end

  // The result side: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    do begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end while (quiet_cycles < WATCHDOG_LIMIT);
    $display("Timed out after %0d cycles without a beat.", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    region_beat_t directed_rows[$];
    int           random_count;
    mismatches    = 0;
    writes_seen   = 0;
    lookups_seen  = 0;
    ignored_seen  = 0;
    hits_seen     = 0;
    misses_seen   = 0;
    no_idle       = 1'b0;
    hold_requests = 0;
    random_count  = 0;
    cur_beat      = '0;
    rst_n                   = 1'b0;
    in_valid                = 1'b0;
    in_action               = '0;
    in_entry_slot           = '0;
    in_region_virtual_base  = '0;
    in_region_physical_base = '0;
    in_region_length        = '0;
    in_lookup_address       = '0;
    for (int k = 0; k < REGION_SLOTS; k++) begin
      virt_tab[k] = '0;
      phys_tab[k] = '0;
      len_tab[k]  = '0;
    end

    // An empty table misses everywhere.
    directed_rows.push_back(lookup_row(ACT_V2P, 64'h0, 1'b1, 64'h0, 1'b1, 4'd0));
    directed_rows.push_back(lookup_row(ACT_P2V, '1, 1'b1, 64'h0, 1'b1, 4'd0));
    directed_rows.push_back(lookup_row(ACT_NONE, 64'h1234, 1'b0, '0, 1'b0, '0));
    directed_rows.push_back(write_row(4'd0, 64'h1000, 64'h8000_0000, 32'h100));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'h1000, 1'b1, 64'h8000_0000, 1'b0, 4'd0));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'h10FF, 1'b1, 64'h8000_00FF, 1'b0, 4'd0));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'h1100, 1'b1, 64'h0, 1'b1, 4'd0));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'h0FFF, 1'b1, 64'h0, 1'b1, 4'd0));
    directed_rows.push_back(lookup_row(ACT_P2V, 64'h8000_0010, 1'b1, 64'h1010, 1'b0, 4'd0));
    // A region running past the top of the address space does not wrap to zero.
    directed_rows.push_back(write_row(4'd15, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 32'hFFFF_FFFF));
    directed_rows.push_back(lookup_row(ACT_V2P, '1, 1'b1, 64'hFF, 1'b0, 4'd15));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'h0, 1'b1, 64'h0, 1'b1, 4'd0));
    // Lower slot overlapping slot 15 wins, and its sum wraps.
    directed_rows.push_back(write_row(4'd3, 64'hFFFF_FFFF_FFFF_FFF0, '1, 32'h10));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'hFFFF_FFFF_FFFF_FFF8, 1'b1, 64'h7, 1'b0, 4'd3));
    directed_rows.push_back(lookup_row(ACT_P2V, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 4'd15));
    directed_rows.push_back(lookup_row(ACT_P2V, 64'hFFFF_FFFE, 1'b0, '0, 1'b0, '0));
    directed_rows.push_back(lookup_row(ACT_P2V, 64'hFFFF_FFFF, 1'b1, 64'h0, 1'b1, 4'd0));
    // A zero-length slot never matches.
    directed_rows.push_back(write_row(4'd5, 64'h2000, 64'h3000, 32'h0));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'h2000, 1'b1, 64'h0, 1'b1, 4'd0));
    directed_rows.push_back(write_row(4'd3, 64'h0, 64'h0, 32'h0));
    directed_rows.push_back(lookup_row(ACT_V2P, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0, '0, 1'b0, '0));
    directed_rows.push_back(lookup_row(ACT_NONE, '1, 1'b0, '0, 1'b0, '0));
    directed_rows.push_back(write_row(4'd15, '1, '1, '1));
    directed_rows.push_back(lookup_row(ACT_V2P, '1, 1'b0, '0, 1'b0, '0));
    directed_rows.push_back(write_row(4'd0, '0, '0, '1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    for (int i = 0; i < FIRST_RANDOM; i++) send_beat(random_region_beat());
    // The sender stays quiet until every result is back.
    in_valid = 1'b0;
    wait_for_drain();
    @(negedge clk);

    no_idle = 1'b1;
    for (int i = 0; i < STEADY_RANDOM; i++) send_beat(random_region_beat());
    no_idle = 1'b0;

    // The receiver stalls for a long stretch while lookups keep coming.
    hold_requests++;
    for (int i = 0; i < BACKLOG_RANDOM; i++) send_beat(random_region_beat());
    in_valid = 1'b0;
    wait_for_drain();
    @(negedge clk);

    for (int i = 0; i < LAST_RANDOM; i++) send_beat(random_region_beat());
    in_valid = 1'b0;
    random_count = FIRST_RANDOM + STEADY_RANDOM + BACKLOG_RANDOM + LAST_RANDOM;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_translations.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_translations.size()));

    $display("Ran %0d directed and %0d random beats: %0d table writes, %0d ignored codes.",
             directed_rows.size(), random_count, writes_seen, ignored_seen);
    $display("Checked %0d lookups (%0d hits, %0d misses), including a %0d-cycle result stall.",
             lookups_seen, hits_seen, misses_seen, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
